### src/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Table geometry, request and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_EDIT   = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADKEY   = 3'd2;
  localparam logic [2:0] ST_DUP      = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] ticket;
    logic signed [31:0] food;
  } entry_t;

  // which data goes out with the result beat
  typedef enum logic [1:0] {
    RES_NONE,
    RES_EDIT,
    RES_READ
  } res_sel_e;

  typedef struct packed {
    logic       load;       // latch request fields
    logic       scan_clr;   // scan pointer to slot zero
    logic       scan_hit;   // scan pointer to slot after the hit
    logic       scan_step;  // read at scan pointer if below count, advance
    logic       rd_slot;    // read at requested slot
    logic       wr_append;  // write new record at count
    logic       wr_edit;    // write new amounts at hit slot
    logic       wr_shift;   // move returned record down one slot
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_we;     // issue result beat
    logic [2:0] res_status;
    res_sel_e   res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       cnt_zero;
    logic       full;
    logic       key_bad;
    logic       slot_ok;
    logic       scan_more;  // scan pointer still below count
    logic       rd_valid;   // read data of a scanned slot is present
    logic       hit;        // that read data matches the key
  } sts_t;

endpackage

### src/krt_datapath.sv
// ----------------------------------------------------------------------------
// krt_datapath: record memory, count, scan pointer and result registers
// Single-port-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module krt_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] record_key_i,
  input  logic signed [31:0] ticket_value_i,
  input  logic signed [31:0] food_value_i,
  input  logic [5:0]         slot_index_i,
  input  krt_pkg::cmd_t      cmd_i,
  output krt_pkg::sts_t      sts_o,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic signed [31:0] old_ticket_o,
  output logic signed [31:0] old_food_o,
  output logic [6:0]         entry_count_o
);
  import krt_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rd_q;

  // latched request
  logic [1:0]         req_q;
  logic signed [31:0] key_q, tick_q, food_q;
  logic [5:0]         slot_q;

  cnt_t count_q, count_d;
  cnt_t ptr_q, ptr_d;
  idx_t rd_idx_q;
  logic rdv_q, rdv_d;

  logic   done_q;
  logic [2:0] status_q;
  logic signed [31:0] okey_q, otick_q, ofood_q;

  logic   scan_more;
  logic   rd_en, wr_en;
  idx_t   rd_addr, wr_addr;
  entry_t wr_data;

  assign scan_more = (ptr_q < count_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q[IDX_W-1:0];
    if (cmd_i.rd_slot) begin
      rd_en   = 1'b1;
      rd_addr = idx_t'(slot_q);
    end else if (cmd_i.scan_step && scan_more) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[IDX_W-1:0];
    wr_data = '{key: key_q, ticket: tick_q, food: food_q};
    if (cmd_i.wr_append) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_edit) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q;
    end else if (cmd_i.wr_shift && rdv_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_q - idx_t'(1);
      wr_data = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    rdv_d = 1'b0;
    if (cmd_i.scan_clr) begin
      ptr_d = '0;
    end else if (cmd_i.scan_hit) begin
      ptr_d = cnt_t'(rd_idx_q) + cnt_t'(1);
    end else if (cmd_i.scan_step && scan_more) begin
      ptr_d = ptr_q + cnt_t'(1);
      rdv_d = 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + cnt_t'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      rdv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      rdv_q   <= rdv_d;
      done_q  <= cmd_i.res_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      key_q  <= record_key_i;
      tick_q <= ticket_value_i;
      food_q <= food_value_i;
      slot_q <= slot_index_i;
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
      case (cmd_i.res_sel)
        RES_EDIT: begin
          okey_q  <= '0;
          otick_q <= rd_q.ticket;
          ofood_q <= rd_q.food;
        end
        RES_READ: begin
          okey_q  <= rd_q.key;
          otick_q <= rd_q.ticket;
          ofood_q <= rd_q.food;
        end
        default: begin
          okey_q  <= '0;
          otick_q <= '0;
          ofood_q <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts_o.req       = req_q;
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.full      = (32'(count_q) >= TABLE_DEPTH);
    sts_o.key_bad   = (key_q == '0) || key_q[31];
    sts_o.slot_ok   = (32'(slot_q) < 32'(count_q));
    sts_o.scan_more = scan_more;
    sts_o.rd_valid  = rdv_q;
    sts_o.hit       = rdv_q && (rd_q.key == key_q);
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_key_o   = okey_q;
  assign old_ticket_o  = otick_q;
  assign old_food_o    = ofood_q;
  assign entry_count_o = 7'(count_q);

endmodule

### src/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl: request sequencer of the keyed record table
// Dispatches a request, runs the key scan and the delete compaction.
// ----------------------------------------------------------------------------
module krt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  krt_pkg::sts_t sts_i,
  output krt_pkg::cmd_t cmd_o
);
  import krt_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SEARCH   = 3'd2;
  localparam logic [2:0] S_SHIFT    = 3'd3;
  localparam logic [2:0] S_RDWAIT   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       scan_done;

  // every issued read has come back without a hit
  assign scan_done = !sts_i.scan_more && !sts_i.rd_valid;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.res_sel    = RES_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_IDLE;
        case (sts_i.req)
          REQ_CREATE: begin
            if (sts_i.full) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = ST_FULL;
            end else if (sts_i.key_bad) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = ST_BADKEY;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_SEARCH;
            end
          end
          REQ_EDIT, REQ_DELETE: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.scan_clr = 1'b1;
              state_d        = S_SEARCH;
            end
          end
          default: begin
            if (sts_i.slot_ok) begin
              cmd_o.rd_slot = 1'b1;
              state_d       = S_RDWAIT;
            end else begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = ST_EMPTY;
            end
          end
        endcase
      end
      S_SEARCH: begin
        if (sts_i.hit) begin
          state_d = S_IDLE;
          case (sts_i.req)
            REQ_CREATE: begin
              cmd_o.res_we     = 1'b1;
              cmd_o.res_status = ST_DUP;
            end
            REQ_EDIT: begin
              cmd_o.wr_edit = 1'b1;
              cmd_o.res_we  = 1'b1;
              cmd_o.res_sel = RES_EDIT;
            end
            default: begin
              cmd_o.scan_hit = 1'b1;
              state_d        = S_SHIFT;
            end
          endcase
        end else if (scan_done) begin
          state_d      = S_IDLE;
          cmd_o.res_we = 1'b1;
          if (sts_i.req == REQ_CREATE) begin
            cmd_o.wr_append = 1'b1;
            cmd_o.cnt_inc   = 1'b1;
          end else begin
            cmd_o.res_status = ST_NOTFOUND;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        cmd_o.wr_shift = 1'b1;
        if (scan_done) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_we  = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RDWAIT: begin
        cmd_o.res_we  = 1'b1;
        cmd_o.res_sel = RES_READ;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### src/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table: packed table of keyed records
// Create, edit, delete and read-by-slot on up to TABLE_DEPTH records
// (key, ticket amount, food amount) kept in insertion order.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; exactly one
// result beat follows, marked by done_o for a single cycle, and the receiver
// cannot hold it off, so capture it on that cycle. entry_count_o is valid with
// the beat and shows the count after the request. Checks that end early (full,
// bad key, empty, slot beyond count) give the beat straight from dispatch; a
// read waits for the registered read data. Create and edit scan the keys one
// slot per cycle through the single read port of the record memory, ending
// early on a hit. Delete scans up to the hit at slot p, then moves each later
// record down one slot, again one per cycle through the same port. busy_o
// drops on the cycle of the beat, and a new request may be accepted then. The
// memory is not cleared at reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
module keyed_record_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] record_key_i,
  input  logic signed [31:0] ticket_value_i,
  input  logic signed [31:0] food_value_i,
  input  logic [5:0]         slot_index_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] found_key_o,
  output logic signed [31:0] old_ticket_o,
  output logic signed [31:0] old_food_o,
  output logic [6:0]         entry_count_o
);
  import krt_pkg::*;

  cmd_t cmd;  // controller -> datapath
  sts_t sts;  // datapath -> controller

  krt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  krt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .record_key_i   (record_key_i),
    .ticket_value_i (ticket_value_i),
    .food_value_i   (food_value_i),
    .slot_index_i   (slot_index_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_key_o    (found_key_o),
    .old_ticket_o   (old_ticket_o),
    .old_food_o     (old_food_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for keyed_record_table
// Drives create, edit, delete and read-by-slot requests with random gaps and
// checks every result beat against a cycle-free table predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import krt_pkg::*;

  localparam int     RANDOM_ITEMS = 750;
  localparam int     PHASE_LEN    = 125;
  localparam int     DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT  = 600000;

  // one request beat as the bench drives it
  typedef struct packed {
    logic [1:0]  req;
    logic [31:0] key;
    logic [31:0] ticket;
    logic [31:0] food;
    logic [5:0]  slot;
  } table_req_t;

  // one result beat as the block should return it
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key;
    logic [31:0] ticket;
    logic [31:0] food;
    logic [6:0]  count;
  } table_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic [1:0]         req_type_i     = '0;
  logic signed [31:0] record_key_i   = '0;
  logic signed [31:0] ticket_value_i = '0;
  logic signed [31:0] food_value_i   = '0;
  logic [5:0]         slot_index_i   = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic signed [31:0] found_key_o;
  logic signed [31:0] old_ticket_o;
  logic signed [31:0] old_food_o;
  logic [6:0]         entry_count_o;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  keyed_record_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .req_type_i     (req_type_i),
    .record_key_i   (record_key_i),
    .ticket_value_i (ticket_value_i),
    .food_value_i   (food_value_i),
    .slot_index_i   (slot_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .found_key_o    (found_key_o),
    .old_ticket_o   (old_ticket_o),
    .old_food_o     (old_food_o),
    .entry_count_o  (entry_count_o)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  table_req_t    pending_q[$];     // requests not yet driven
  table_result_t result_q[$];      // predicted beats not yet returned
  int            queued_cnt   = 0; // requests put in pending_q
  int            issued_cnt   = 0; // requests put on the pins
  int            accepted_cnt = 0; // requests taken by the block
  int            fail_cnt     = 0;
  longint        cycle_cnt    = 0;

  // predictor copy of the table
  logic [31:0]   pred_key[TABLE_DEPTH];
  logic [31:0]   pred_ticket[TABLE_DEPTH];
  logic [31:0]   pred_food[TABLE_DEPTH];
  int            pred_count = 0;

  // stimulus-side key list, in table order, to aim edits and deletes at hits
  logic [31:0]   live_keys[$];

  // --------------------------------------------------------------------------
  // Predictor: lowest matching slot below the count, or -1
  // --------------------------------------------------------------------------
  function automatic int find_key(logic [31:0] key);
    for (int n = 0; n < pred_count; n++) begin
      if (pred_key[n] == key) return n;
    end
    return -1;
  endfunction

  // applies one request to the predicted table and returns the expected beat
  function automatic table_result_t apply_request(table_req_t rq);
    table_result_t res;
    int            pos;
    res = '0;
    res.status = ST_OK;
    case (rq.req)
      REQ_CREATE: begin
        // full wins over a bad key, a bad key over a duplicate
        if (pred_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else if (rq.key == 32'd0 || rq.key[31]) begin
          res.status = ST_BADKEY;
        end else if (find_key(rq.key) >= 0) begin
          res.status = ST_DUP;
        end else begin
          pred_key[pred_count]    = rq.key;
          pred_ticket[pred_count] = rq.ticket;
          pred_food[pred_count]   = rq.food;
          pred_count++;
        end
      end
      REQ_EDIT, REQ_DELETE: begin
        pos = find_key(rq.key);
        if (pred_count == 0) begin
          res.status = ST_EMPTY;
        end else if (pos < 0) begin
          res.status = ST_NOTFOUND;
        end else if (rq.req == REQ_EDIT) begin
          res.ticket       = pred_ticket[pos];
          res.food         = pred_food[pos];
          pred_ticket[pos] = rq.ticket;
          pred_food[pos]   = rq.food;
        end else begin
          // close the gap: later records move down one slot
          for (int n = pos; n + 1 < pred_count; n++) begin
            pred_key[n]    = pred_key[n+1];
            pred_ticket[n] = pred_ticket[n+1];
            pred_food[n]   = pred_food[n+1];
          end
          pred_count--;
        end
      end
      default: begin
        if (int'(rq.slot) >= pred_count) begin
          res.status = ST_EMPTY;
        end else begin
          res.key    = pred_key[rq.slot];
          res.ticket = pred_ticket[rq.slot];
          res.food   = pred_food[rq.slot];
        end
      end
    endcase
    res.count = pred_count[6:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // queue a request and keep the stimulus key list in step with the table
  task automatic queue_req(logic [1:0] req, logic [31:0] key, logic [31:0] ticket,
                           logic [31:0] food, logic [5:0] slot);
    table_req_t rq;
    int         pos;
    rq.req    = req;
    rq.key    = key;
    rq.ticket = ticket;
    rq.food   = food;
    rq.slot   = slot;
    pending_q.push_back(rq);
    queued_cnt++;
    pos = -1;
    foreach (live_keys[i]) begin
      if (pos < 0 && live_keys[i] == key) pos = i;
    end
    if (req == REQ_CREATE && live_keys.size() < TABLE_DEPTH && key != 32'd0 &&
        !key[31] && pos < 0) begin
      live_keys.push_back(key);
    end else if (req == REQ_DELETE && pos >= 0) begin
      live_keys.delete(pos);
    end
  endtask

  // key for a create: mostly a small pool so duplicates and full tables occur
  function automatic logic [31:0] create_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return 32'd0;
    if (pick < 16) return $urandom();
    if (pick < 26 && live_keys.size() != 0)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    return $urandom_range(200, 1);
  endfunction

  // key for an edit or delete: mostly a stored one
  function automatic logic [31:0] target_key();
    if (live_keys.size() != 0 && $urandom_range(99) < 80)
      return live_keys[$urandom_range(live_keys.size() - 1)];
    if ($urandom_range(1) == 0) return $urandom();
    return $urandom_range(200, 1);
  endfunction

  function automatic logic [5:0] read_slot();
    if (live_keys.size() != 0 && $urandom_range(99) < 70)
      return 6'($urandom_range(live_keys.size() - 1));
    return 6'($urandom_range(63));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new beat at the falling edge once the previous one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || accepted_cnt == issued_cnt) begin
        // idles about a third of the time, except in one long burst window
        if (pending_q.size() == 0 ||
            (!(issued_cnt >= 300 && issued_cnt < 450) && $urandom_range(99) < 32)) begin
          start_i <= 1'b0;
        end else begin
          req_type_i     <= pending_q[0].req;
          record_key_i   <= pending_q[0].key;
          ticket_value_i <= pending_q[0].ticket;
          food_value_i   <= pending_q[0].food;
          slot_index_i   <= pending_q[0].slot;
          start_i        <= 1'b1;
          void'(pending_q.pop_front());
          issued_cnt     <= issued_cnt + 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the result beat first, then log a newly accepted request
  // (a request may be taken on the very cycle of the previous beat)
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    table_result_t exp_res;
    table_req_t    rq;
    if (rst_ni) begin
      if (done_o) begin
        if (result_q.size() == 0) begin
          $error("unexpected result beat: status %0d count %0d", status_o, entry_count_o);
          fail_cnt++;
        end else begin
          exp_res = result_q.pop_front();
          if (status_o !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status_o);
            fail_cnt++;
          end
          if (found_key_o !== exp_res.key) begin
            $error("found_key: expected %0h, got %0h", exp_res.key, found_key_o);
            fail_cnt++;
          end
          if (old_ticket_o !== exp_res.ticket) begin
            $error("old_ticket: expected %0h, got %0h", exp_res.ticket, old_ticket_o);
            fail_cnt++;
          end
          if (old_food_o !== exp_res.food) begin
            $error("old_food: expected %0h, got %0h", exp_res.food, old_food_o);
            fail_cnt++;
          end
          if (entry_count_o !== exp_res.count) begin
            $error("entry_count: expected %0d, got %0d", exp_res.count, entry_count_o);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_o) begin
        rq.req    = req_type_i;
        rq.key    = record_key_i;
        rq.ticket = ticket_value_i;
        rq.food   = food_value_i;
        rq.slot   = slot_index_i;
        result_q.push_back(apply_request(rq));
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed requests, random phases, drain, verdict
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    int          mode;

    // empty table on read, edit and delete requests
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd0);
    queue_req(REQ_EDIT,   32'd5, 32'd1, 32'd1, 6'd0);
    queue_req(REQ_DELETE, 32'd5, 32'd0, 32'd0, 6'd63);
    // keys not above zero
    queue_req(REQ_CREATE, 32'd0,          32'd7, 32'd7, 6'd0);
    queue_req(REQ_CREATE, 32'hFFFF_FFFF,  32'd7, 32'd7, 6'd0);
    queue_req(REQ_CREATE, 32'h8000_0000,  32'd7, 32'd7, 6'd0);
    // extreme keys and amounts
    queue_req(REQ_CREATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 6'd0);
    queue_req(REQ_CREATE, 32'd1, 32'hFFFF_FFFF, 32'd0, 6'd0);
    queue_req(REQ_CREATE, 32'd1, 32'd3, 32'd3, 6'd0);                   // duplicate
    queue_req(REQ_EDIT,   32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 6'd0);
    queue_req(REQ_EDIT,   32'd2, 32'd9, 32'd9, 6'd0);                   // not found
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd0);
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd1);
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd2);                   // at count
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd63);
    // delete at the head shifts the rest down
    queue_req(REQ_DELETE, 32'h7FFF_FFFF, 32'd0, 32'd0, 6'd0);
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd0);
    queue_req(REQ_DELETE, 32'd3, 32'd0, 32'd0, 6'd0);                   // not found
    queue_req(REQ_DELETE, 32'd1, 32'd0, 32'd0, 6'd0);                   // back to empty
    queue_req(REQ_READ,   32'd0, 32'd0, 32'd0, 6'd0);

    // random phases: fill, mixed, drain, repeated
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = (i / PHASE_LEN) % 3;
      pick = $urandom_range(99);
      if (mode == 0) begin
        pick = (pick < 75) ? 0 : (pick < 85) ? 1 : (pick < 90) ? 2 : 3;
      end else if (mode == 1) begin
        pick = pick / 25;
      end else begin
        pick = (pick < 10) ? 0 : (pick < 25) ? 1 : (pick < 80) ? 2 : 3;
      end
      case (pick)
        0:       queue_req(REQ_CREATE, create_key(), $urandom(), $urandom(),
                           6'($urandom_range(63)));
        1:       queue_req(REQ_EDIT, target_key(), $urandom(), $urandom(),
                           6'($urandom_range(63)));
        2:       queue_req(REQ_DELETE, target_key(), $urandom(), $urandom(),
                           6'($urandom_range(63)));
        default: queue_req(REQ_READ, $urandom(), $urandom(), $urandom(), read_slot());
      endcase
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || accepted_cnt != queued_cnt || result_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
